### design/pwq_pkg.sv
`timescale 1ns / 1ps
package pwq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int TASK_COUNT    = 32;
  localparam int PRIORITY_BITS = 8;

  localparam int CMD_W       = 2;
  localparam int TASK_W      = 5;
  localparam int PRI_IN_W    = 8;
  localparam int STATUS_W    = 3;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TASK_IDX_W  = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  localparam logic [CMD_W-1:0] CMD_BLOCK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WAKE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WAKE_FST = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WAKE_ALL = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_WAITING = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } pwq_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic res_last;
  } pwq_sts_t;

endpackage

### design/pwq_in_if.sv
`timescale 1ns / 1ps
interface pwq_in_if
  import pwq_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [TASK_W-1:0]   task_id;
  logic [PRI_IN_W-1:0] priority_req;

  modport source (output valid, command, task_id, priority_req, input ready);
  modport sink   (input valid, command, task_id, priority_req, output ready);
endinterface

### design/pwq_out_if.sv
`timescale 1ns / 1ps
interface pwq_out_if
  import pwq_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TASK_W-1:0]   released_task;
  logic                released_valid;
  logic                last;
  logic                queue_empty;

  modport source (output valid, status, released_task, released_valid, last, queue_empty,
                  input ready);
  modport sink   (input valid, status, released_task, released_valid, last, queue_empty,
                  output ready);
endinterface

### design/priority_wait_queue.sv
`timescale 1ns / 1ps
// Priority ordered wait queue of task ids, lower priority value first and
// first in, first out among equal priorities, with a waiting flag per task.
// The input channel carries one command per transfer: block (insert in order),
// wake a named task, wake the first task, or wake all queued tasks. The result
// channel carries the status, the released task, its valid bit, a last flag on
// the final result of a command, and whether the queue is empty afterwards.
// Block, wake and wake first give one result; wake all gives one result per
// queued task (or one when the queue is empty), with last on the final one.
// An input transfer is latched into the command register by the accept step,
// and the execute step then loads its result into the output register. Wake
// all streams one result per cycle from the controller's execute state for
// as long as the receiver takes them. Commands are handled one at a time,
// through the accept and execute steps of the controller and the single
// output register.
// If the receiver stalls, the result waits in the output register and the
// execute step holds until that register is free; a new command is not taken
// before all results of the current one have been loaded.
// Reset empties the queue and clears every waiting flag and the output valid.
module priority_wait_queue
  import pwq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  pwq_in_if.sink   in_ch,
  pwq_out_if.source out_ch
);

  pwq_ctl_t ctl;
  pwq_sts_t sts;

  // The controller sequences accept and execute; the datapath holds the queue.
  pwq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  pwq_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .in_command         (in_ch.command),
    .in_task_id         (in_ch.task_id),
    .in_priority_req    (in_ch.priority_req),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_released_task  (out_ch.released_task),
    .out_released_valid (out_ch.released_valid),
    .out_last           (out_ch.last),
    .out_queue_empty    (out_ch.queue_empty)
  );

  // After an input transfer the block is busy executing the command.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while a command is executing");

  // Results before the last one only come from wake all and always release a task.
  a_mid_result_releases: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last |-> out_ch.released_valid && out_ch.status == ST_OK)
    else $error("non-final result without a released task");

  // While a non-final wake all result waits, the controller is still executing,
  // so no new command is accepted.
  a_stream_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last |-> !in_ch.ready)
    else $error("input open during a wake all stream");

  // A released task is only reported with ok status.
  a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.released_valid |-> out_ch.status == ST_OK)
    else $error("released task reported with an error status");

  // Reset leaves no result pending.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

### design/pwq_ctrl.sv
`timescale 1ns / 1ps
module pwq_ctrl
  import pwq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pwq_sts_t sts,
  output pwq_ctl_t ctl
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl.load  = 1'b0;
    ctl.exec  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // Each execute step produces one result, so it waits for a free output slot.
        if (sts.out_free) begin
          ctl.exec = 1'b1;
          if (sts.res_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/pwq_dpath.sv
`timescale 1ns / 1ps
module pwq_dpath
  import pwq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  pwq_ctl_t            ctl,
  output pwq_sts_t            sts,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [TASK_W-1:0]   in_task_id,
  input  logic [PRI_IN_W-1:0] in_priority_req,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [TASK_W-1:0]   out_released_task,
  output logic                out_released_valid,
  output logic                out_last,
  output logic                out_queue_empty
);

  // Latched command.
  logic [CMD_W-1:0]         cmd_r;
  logic [TASK_W-1:0]        tid_r;
  logic [PRIORITY_BITS-1:0] pri_r;

  // Sorted cell chain, cell 0 is the head.
  logic [TASK_W-1:0]        slot_task_r [QUEUE_DEPTH];
  logic [TASK_W-1:0]        slot_task_nxt [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] slot_pri_r [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] slot_pri_nxt [QUEUE_DEPTH];
  logic [OCC_W-1:0]         occ_r;
  logic [OCC_W-1:0]         occ_nxt;
  logic [TASK_COUNT-1:0]    wait_r;
  logic [TASK_COUNT-1:0]    wait_nxt;

  // Result register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [TASK_W-1:0]   out_task_r;
  logic                out_rvalid_r;
  logic                out_last_r;
  logic                out_empty_r;

  logic [QUEUE_DEPTH-1:0] occupied;
  logic [QUEUE_DEPTH-1:0] gt;
  logic [QUEUE_DEPTH-1:0] hit;
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] pre;
  logic [TASK_IDX_W-1:0]  wait_idx;
  logic [TASK_IDX_W-1:0]  clr_idx;
  logic                   known;
  logic                   wflag;
  logic                   head_known;

  logic [STATUS_W-1:0] status_c;
  logic [TASK_W-1:0]   rel_task_c;
  logic                rel_valid_c;
  logic                last_c;
  logic                ins;
  logic                rem;
  logic                set_w;
  logic                clr_w;

  assign known      = (32'(tid_r) < TASK_COUNT);
  assign wait_idx   = TASK_IDX_W'(tid_r);
  assign wflag      = known && wait_r[wait_idx];
  assign head_known = (32'(slot_task_r[0]) < TASK_COUNT);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      occupied[i] = (OCC_W'(i) < occ_r);
      // Cells past the tail count as lower priority than anything new.
      gt[i]       = !occupied[i] || (slot_pri_r[i] > pri_r);
      hit[i]      = occupied[i] && (slot_task_r[i] == tid_r);
    end
  end

  // Command decode.
  always_comb begin
    status_c    = ST_OK;
    rel_task_c  = '0;
    rel_valid_c = 1'b0;
    last_c      = 1'b1;
    ins         = 1'b0;
    rem         = 1'b0;
    set_w       = 1'b0;
    clr_w       = 1'b0;
    clr_idx     = wait_idx;
    match       = '0;
    case (cmd_r)
      CMD_BLOCK: begin
        if (!known) begin
          status_c = ST_NOT_WAITING;
        end else if (wflag) begin
          status_c = ST_ALREADY;
        end else if (occ_r == OCC_W'(QUEUE_DEPTH)) begin
          status_c = ST_FULL;
        end else begin
          ins   = 1'b1;
          set_w = 1'b1;
        end
      end
      CMD_WAKE: begin
        if (!wflag) begin
          status_c = ST_NOT_WAITING;
        end else begin
          rem         = 1'b1;
          match       = hit;
          clr_w       = 1'b1;
          rel_valid_c = 1'b1;
          rel_task_c  = tid_r;
        end
      end
      default: begin
        if (occ_r == '0) begin
          status_c = ST_EMPTY;
        end else begin
          rem         = 1'b1;
          match[0]    = 1'b1;
          clr_w       = head_known;
          clr_idx     = TASK_IDX_W'(slot_task_r[0]);
          rel_valid_c = 1'b1;
          rel_task_c  = slot_task_r[0];
          last_c      = (cmd_r == CMD_WAKE_FST) || (occ_r == OCC_W'(1));
        end
      end
    endcase
  end

  // Cell chain update: each cell looks only at itself and its neighbors.
  always_comb begin
    pre[0] = match[0];
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      pre[i] = pre[i-1] | match[i];
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_task_nxt[i] = slot_task_r[i];
      slot_pri_nxt[i]  = slot_pri_r[i];
    end
    occ_nxt = occ_r;
    if (ctl.exec && ins) begin
      occ_nxt = occ_r + OCC_W'(1);
      if (gt[0]) begin
        slot_task_nxt[0] = tid_r;
        slot_pri_nxt[0]  = pri_r;
      end
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (gt[i] && !gt[i-1]) begin
          slot_task_nxt[i] = tid_r;
          slot_pri_nxt[i]  = pri_r;
        end else if (gt[i]) begin
          slot_task_nxt[i] = slot_task_r[i-1];
          slot_pri_nxt[i]  = slot_pri_r[i-1];
        end
      end
    end else if (ctl.exec && rem) begin
      occ_nxt = occ_r - OCC_W'(1);
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        if (pre[i]) begin
          slot_task_nxt[i] = slot_task_r[i+1];
          slot_pri_nxt[i]  = slot_pri_r[i+1];
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < TASK_COUNT; j++) begin
      wait_nxt[j] = wait_r[j];
      if (ctl.exec && set_w && (wait_idx == TASK_IDX_W'(j))) begin
        wait_nxt[j] = 1'b1;
      end
      if (ctl.exec && clr_w && (clr_idx == TASK_IDX_W'(j))) begin
        wait_nxt[j] = 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.res_last = last_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r  <= occ_nxt;
      wait_r <= wait_nxt;
      if (ctl.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_command;
      tid_r <= in_task_id;
      pri_r <= PRIORITY_BITS'(in_priority_req);
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_task_r[i] <= slot_task_nxt[i];
      slot_pri_r[i]  <= slot_pri_nxt[i];
    end
    if (ctl.exec) begin
      out_status_r <= status_c;
      out_task_r   <= rel_task_c;
      out_rvalid_r <= rel_valid_c;
      out_last_r   <= last_c;
      out_empty_r  <= (occ_nxt == '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_released_task  = out_task_r;
  assign out_released_valid = out_rvalid_r;
  assign out_last           = out_last_r;
  assign out_queue_empty    = out_empty_r;

endmodule

### test/pwq_checker.sv
`timescale 1ns / 1ps
module pwq_checker
  import pwq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pwq_in_if    in_mon,
  pwq_out_if   out_mon,
  output int   mismatch_count,
  output int   outstanding
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TASK_W-1:0]   released_task;
    logic                released_valid;
    logic                last;
    logic                queue_empty;
  } wake_result_t;

  // Shadow copy of the wait queue; slot 0 is the head.
  logic [TASK_W-1:0]        shadow_task [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] shadow_pri  [QUEUE_DEPTH];
  int                       shadow_depth;
  logic                     shadow_waiting [TASK_COUNT];
  wake_result_t             expected_wakes[$];
  int                       bad_results;

  function automatic void queue_wake_result(logic [STATUS_W-1:0] status,
                                            logic [TASK_W-1:0] released,
                                            logic valid, logic last);
    wake_result_t r;
    r.status         = status;
    r.released_task  = valid ? released : '0;
    r.released_valid = valid;
    r.last           = last;
    r.queue_empty    = (shadow_depth == 0);
    expected_wakes.push_back(r);
  endfunction

  function automatic void drop_slot(int pos);
    for (int i = pos; i < shadow_depth - 1; i++) begin
      shadow_task[i] = shadow_task[i + 1];
      shadow_pri[i]  = shadow_pri[i + 1];
    end
    if (shadow_depth > 0) shadow_depth--;
  endfunction

  function automatic void pop_head_wake(logic last_of_stream);
    logic [TASK_W-1:0] head;
    head = shadow_task[0];
    drop_slot(0);
    if (int'(head) < TASK_COUNT) shadow_waiting[head] = 1'b0;
    queue_wake_result(ST_OK, head, 1'b1, last_of_stream || (shadow_depth == 0));
  endfunction

  function automatic void predict_wakes(logic [CMD_W-1:0] cmd, logic [TASK_W-1:0] tid,
                                        logic [PRI_IN_W-1:0] pri_in);
    logic [PRIORITY_BITS-1:0] pri;
    logic                     known;
    int                       pos;
    pri   = pri_in[PRIORITY_BITS-1:0];
    known = (int'(tid) < TASK_COUNT);
    case (cmd)
      CMD_BLOCK: begin
        if (!known) begin
          queue_wake_result(ST_NOT_WAITING, '0, 1'b0, 1'b1);
        end else if (shadow_waiting[tid]) begin
          queue_wake_result(ST_ALREADY, '0, 1'b0, 1'b1);
        end else if (shadow_depth >= QUEUE_DEPTH) begin
          queue_wake_result(ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          // Goes in front of the first task with a strictly larger value.
          pos = shadow_depth;
          for (int i = 0; i < shadow_depth; i++) begin
            if (shadow_pri[i] > pri) begin
              pos = i;
              break;
            end
          end
          for (int i = shadow_depth; i > pos; i--) begin
            shadow_task[i] = shadow_task[i - 1];
            shadow_pri[i]  = shadow_pri[i - 1];
          end
          shadow_task[pos] = tid;
          shadow_pri[pos]  = pri;
          shadow_depth++;
          shadow_waiting[tid] = 1'b1;
          queue_wake_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      CMD_WAKE: begin
        if (!known || !shadow_waiting[tid]) begin
          queue_wake_result(ST_NOT_WAITING, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_depth; i++) begin
            if (shadow_task[i] == tid) begin
              drop_slot(i);
              break;
            end
          end
          shadow_waiting[tid] = 1'b0;
          queue_wake_result(ST_OK, tid, 1'b1, 1'b1);
        end
      end
      CMD_WAKE_FST: begin
        if (shadow_depth == 0) queue_wake_result(ST_EMPTY, '0, 1'b0, 1'b1);
        else pop_head_wake(1'b1);
      end
      CMD_WAKE_ALL: begin
        if (shadow_depth == 0) queue_wake_result(ST_EMPTY, '0, 1'b0, 1'b1);
        else while (shadow_depth > 0) pop_head_wake(1'b0);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    wake_result_t got;
    wake_result_t want;
    if (!rst_n) begin
      shadow_depth = 0;
      foreach (shadow_waiting[i]) shadow_waiting[i] = 1'b0;
      expected_wakes.delete();
      bad_results = 0;
    end else begin
      // Results are checked before this edge's command is predicted, since a
      // result can never come out in the same cycle as its command.
      if (out_mon.valid && out_mon.ready) begin
        got.status         = out_mon.status;
        got.released_task  = out_mon.released_task;
        got.released_valid = out_mon.released_valid;
        got.last           = out_mon.last;
        got.queue_empty    = out_mon.queue_empty;
        if (expected_wakes.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: unexpected result status %0d task %0d valid %0b last %0b empty %0b",
                     $realtime, got.status, got.released_task, got.released_valid,
                     got.last, got.queue_empty);
        end else begin
          want = expected_wakes.pop_front();
          if (got.status !== want.status || got.released_task !== want.released_task ||
              got.released_valid !== want.released_valid || got.last !== want.last ||
              got.queue_empty !== want.queue_empty) begin
            bad_results++;
            if (bad_results <= 10)
              $display("%0t: result mismatch, expected status %0d task %0d valid %0b last %0b empty %0b, got status %0d task %0d valid %0b last %0b empty %0b",
                       $realtime, want.status, want.released_task, want.released_valid,
                       want.last, want.queue_empty, got.status, got.released_task,
                       got.released_valid, got.last, got.queue_empty);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_wakes(in_mon.command, in_mon.task_id, in_mon.priority_req);
    end
    mismatch_count <= bad_results;
    outstanding    <= expected_wakes.size();
  end

endmodule

### test/priority_wait_queue_test.sv
`timescale 1ns / 1ps
// Testbench top: makes the clock, the reset and the traffic on both channels,
// and gives the verdict. All prediction and comparison live in pwq_checker.
module priority_wait_queue_test;
  import pwq_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RESET_CYCLES    = 12;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES    = 16;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Idle chances in percent per cycle, changed between phases by the stimulus.
  int   send_idle = 0;
  int   recv_idle = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  logic hold_off_req = 1'b0;

  int   errors;
  int   pending;
  int   cycles = 0;

  pwq_in_if  in_ch ();
  pwq_out_if out_ch ();

  priority_wait_queue uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pwq_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (errors),
    .outstanding    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog. The slowest correct run stays well within this limit,
  // even with every command streaming sixteen results into a stalled receiver.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver. Ready changes only at the falling edge. When a hold-off is asked
  // for, ready stays low for a long stretch so that the result register fills,
  // the controller stops executing and the input channel backs up.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // Offers one command and returns at the falling edge after its transfer.
  // Each call starts at a falling edge, so valid gets one assignment per step
  // and stays high across back-to-back commands.
  task automatic send_command(input logic [CMD_W-1:0]    cmd,
                              input logic [TASK_W-1:0]   tid,
                              input logic [PRI_IN_W-1:0] pri);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.task_id      <= tid;
    in_ch.priority_req <= pri;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random traffic in stretches of sixteen commands. Each stretch leans toward
  // filling, mixing or draining, so the queue reaches both full and empty and
  // wake all streams of every length show up. Half the priorities come from a
  // narrow range to produce many ties and exercise first in, first out order.
  task automatic run_phase(input int count);
    int                  block_pct;
    int                  pick;
    logic [CMD_W-1:0]    cmd;
    logic [PRI_IN_W-1:0] pri;
    block_pct = 55;
    for (int k = 0; k < count; k++) begin
      if (k % 16 == 0) begin
        case ($urandom_range(0, 2))
          0:       block_pct = 85;
          1:       block_pct = 55;
          default: block_pct = 25;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < block_pct)                                  cmd = CMD_BLOCK;
      else if (pick < block_pct + (100 - block_pct) * 4 / 10) cmd = CMD_WAKE;
      else if (pick < block_pct + (100 - block_pct) * 8 / 10) cmd = CMD_WAKE_FST;
      else                                                   cmd = CMD_WAKE_ALL;
      if ($urandom_range(0, 1) == 0) pri = PRI_IN_W'($urandom_range(0, 7));
      else                           pri = PRI_IN_W'($urandom_range(0, 255));
      send_command(cmd, TASK_W'($urandom_range(0, TASK_COUNT - 1)), pri);
    end
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_BLOCK;
    in_ch.task_id      = '0;
    in_ch.priority_req = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle = 31;
    recv_idle = 55;

    // Directed part. Wake first, wake all and a named wake on an empty queue.
    send_command(CMD_WAKE_FST, '0, '0);
    send_command(CMD_WAKE_ALL, '0, '0);
    send_command(CMD_WAKE, 5'd5, '0);
    // Priority extremes, and two tasks of equal priority that must stay in
    // arrival order.
    send_command(CMD_BLOCK, 5'd0, 8'd255);
    send_command(CMD_BLOCK, 5'd31, 8'd0);
    send_command(CMD_BLOCK, 5'd7, 8'd128);
    send_command(CMD_BLOCK, 5'd9, 8'd128);
    // Blocking a task that already waits leaves the queue alone.
    send_command(CMD_BLOCK, 5'd7, 8'd3);
    // Named wake from the middle, then a pop of the head.
    send_command(CMD_WAKE, 5'd9, '0);
    send_command(CMD_WAKE_FST, '0, '0);
    // Fill the queue to its depth, then try one more block into the full queue.
    for (int t = 16; t < 30; t++)
      send_command(CMD_BLOCK, TASK_W'(t), PRI_IN_W'($urandom_range(0, 255)));
    send_command(CMD_BLOCK, 5'd30, 8'd1);
    // A full queue streams out as sixteen results with last on the final one.
    send_command(CMD_WAKE_ALL, '0, '0);
    send_command(CMD_WAKE, 5'd7, '0);

    // Random part in three phases: sender idles less than the receiver, then
    // the other way round, then neither idles. The last phase opens with a
    // long receiver hold-off while the sender keeps offering commands.
    run_phase(124);
    send_idle = 55;
    recv_idle = 31;
    run_phase(123);
    send_idle = 0;
    recv_idle = 0;
    hold_off_req = 1'b1;
    run_phase(123);
    in_ch.valid <= 1'b0;

    // Let every expected result arrive, then keep watching for any stray
    // result before the verdict.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
